[sv/assert_macros.svh]
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vlt_pkg.sv]
// Types, constants and register codes of the video line timing generator.
`default_nettype none

package vlt_pkg;

	localparam int LINE_BITS = 10;
	localparam int LCNT_W    = 11;
	localparam int CMP_W     = 10;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 11;

	// Widths that hold both the counter and the configured values.
	localparam int NEXT_W = (LINE_BITS + 1 > LCNT_W) ? LINE_BITS + 1 : LCNT_W;
	localparam int EQ_W   = (LINE_BITS > CMP_W) ? LINE_BITS : CMP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_COUNT  = 3'd0,
		REG_VBI_LINE    = 3'd1,
		REG_VBO_LINE    = 3'd2,
		REG_VS_START    = 3'd3,
		REG_VS_END      = 3'd4,
		REG_HB_LINE     = 3'd5,
		REG_HB_MODE     = 3'd6,
		REG_INTERLACE   = 3'd7
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] HB_MODE_CMP   = 2'd0;
	localparam logic [MODE_W-1:0] HB_MODE_EVERY = 2'd2;

	typedef struct packed {
		logic [LCNT_W-1:0] line_count;
		logic [CMP_W-1:0]  vbi_line;
		logic [CMP_W-1:0]  vbo_line;
		logic [CMP_W-1:0]  vs_start;
		logic [CMP_W-1:0]  vs_end;
		logic [CMP_W-1:0]  hb_line;
		logic [MODE_W-1:0] hb_mode;
		logic              interlace;
	} cfg_t;

	typedef struct packed {
		logic [LINE_BITS-1:0] scanline;
		logic                 vsync;
		logic                 field;
	} state_t;

	typedef struct packed {
		logic [CMP_W-1:0] line_number;
		logic             field_bit;
		logic             blank_flag;
		logic             vsync_flag;
		logic             irq_vblank_in;
		logic             irq_vblank_out;
		logic             irq_hblank;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		line_count: LCNT_W'(263),
		vbi_line:   CMP_W'(260),
		vbo_line:   CMP_W'(21),
		vs_start:   CMP_W'(260),
		vs_end:     CMP_W'(21),
		hb_line:    CMP_W'(797),
		hb_mode:    HB_MODE_CMP,
		interlace:  1'b0
	};

endpackage

`default_nettype wire

[sv/vlt_if.sv]
// Request and status stream interfaces of the video line timing generator.
`default_nettype none

interface vlt_cmd_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink   (input valid, input advance, output ready);
endinterface

interface vlt_status_if;
	logic                        valid;
	logic                        ready;
	logic [vlt_pkg::CMP_W-1:0]   line_number;
	logic                        field_bit;
	logic                        blank_flag;
	logic                        vsync_flag;
	logic                        irq_vblank_in;
	logic                        irq_vblank_out;
	logic                        irq_hblank;

	modport source (
		output valid, output line_number, output field_bit, output blank_flag,
		output vsync_flag, output irq_vblank_in, output irq_vblank_out,
		output irq_hblank, input ready
	);
	modport sink (
		input valid, input line_number, input field_bit, input blank_flag,
		input vsync_flag, input irq_vblank_in, input irq_vblank_out,
		input irq_hblank, output ready
	);
endinterface

`default_nettype wire

[sv/video_line_timing_generator.sv]
// Video line timing generator: scanline counter, vsync level and line interrupts.
//
// Usage:
//   cmd    : one request per line event; advance=1 steps the scanline counter
//            by one line (wrapping at line_count), advance=0 only asks for status.
//   status : exactly one result per request, in order, carrying the line number,
//            field, blank and vsync levels and the three interrupt pulses.
//   cfg    : cfg_we/cfg_index/cfg_data write one register per cycle; write only
//            while no request is in flight.
// Timing: the line step is a single pass of compare logic, and its result is
//   registered in the result register, or in the skid register while status
//   stalls. One request can be taken every cycle while cmd.ready is high.
// Stall: a skid register sits behind the result register, so one more request
//   is taken while a result waits; cmd.ready drops once both are full.
// Reset: arst_n clears the scanline, vsync level and field, empties both result
//   registers and loads the configuration defaults (263 lines per frame).
`default_nettype none

`include "assert_macros.svh"

module video_line_timing_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	vlt_cmd_if.sink                         cmd,
	vlt_status_if.source                    status,
	input  logic                            cfg_we,
	input  logic [vlt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vlt_pkg::CFG_DAT_W-1:0]   cfg_data
);

	vlt_pkg::cfg_t    cfg_q;
	vlt_pkg::state_t  state_q;
	vlt_pkg::state_t  state_nxt;
	vlt_pkg::result_t res;
	vlt_pkg::result_t out_q;
	vlt_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             acc;
	logic             take;

	assign cmd.ready = !skid_valid_q;
	assign acc       = cmd.valid && !skid_valid_q;
	assign take      = out_valid_q && status.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= vlt_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (vlt_pkg::cfg_reg_t'(cfg_index))
				vlt_pkg::REG_LINE_COUNT: cfg_q.line_count <= cfg_data;
				vlt_pkg::REG_VBI_LINE:   cfg_q.vbi_line <= cfg_data[vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_VBO_LINE:   cfg_q.vbo_line <= cfg_data[vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_VS_START:   cfg_q.vs_start <= cfg_data[vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_VS_END:     cfg_q.vs_end   <= cfg_data[vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_HB_LINE:    cfg_q.hb_line  <= cfg_data[vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_HB_MODE:    cfg_q.hb_mode  <= cfg_data[vlt_pkg::MODE_W-1:0];
				vlt_pkg::REG_INTERLACE:  cfg_q.interlace <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vlt_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.advance (cmd.advance),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (acc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || acc;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (acc && out_valid_q && !take) begin
			skid_q <= res;
		end
	end

	assign status.valid          = out_valid_q;
	assign status.line_number    = out_q.line_number;
	assign status.field_bit      = out_q.field_bit;
	assign status.blank_flag     = out_q.blank_flag;
	assign status.vsync_flag     = out_q.vsync_flag;
	assign status.irq_vblank_in  = out_q.irq_vblank_in;
	assign status.irq_vblank_out = out_q.irq_vblank_out;
	assign status.irq_hblank     = out_q.irq_hblank;

	`ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with result register empty")
	`ASSERT_NEXT(a_status_keeps_line, acc && !cmd.advance, $stable(state_q), "status request moved state")
	`ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_q), $past(out_valid_q && !status.ready), "skid filled without stall")

endmodule

`default_nettype wire

[sv/vlt_step.sv]
// Line step logic: next counter state and the status of one request.
`default_nettype none

module vlt_step (
	input  vlt_pkg::cfg_t    cfg,
	input  vlt_pkg::state_t  cur,
	input  logic             advance,
	output vlt_pkg::state_t  nxt,
	output vlt_pkg::result_t res
);

	logic [vlt_pkg::NEXT_W-1:0]    inc;
	logic [vlt_pkg::LINE_BITS-1:0] line;
	logic [vlt_pkg::EQ_W-1:0]      line_x;
	logic                          hit_vbi, hit_vbo, hit_vss, hit_vse, hit_hb;
	logic                          hb_pulse;
	logic                          vs;
	logic                          fld;

	always_comb begin
		inc  = vlt_pkg::NEXT_W'(cur.scanline) + vlt_pkg::NEXT_W'(1);
		// wrap at or past the line count, so a shrunken count restarts at 0
		if (inc >= vlt_pkg::NEXT_W'(cfg.line_count)) begin
			line = '0;
		end else begin
			line = inc[vlt_pkg::LINE_BITS-1:0];
		end
		if (!advance) begin
			line = cur.scanline;
		end
		line_x = vlt_pkg::EQ_W'(line);

		hit_vbi = line_x == vlt_pkg::EQ_W'(cfg.vbi_line);
		hit_vbo = line_x == vlt_pkg::EQ_W'(cfg.vbo_line);
		hit_vss = line_x == vlt_pkg::EQ_W'(cfg.vs_start);
		hit_vse = line_x == vlt_pkg::EQ_W'(cfg.vs_end);
		hit_hb  = line_x == vlt_pkg::EQ_W'(cfg.hb_line);

		case (cfg.hb_mode)
			vlt_pkg::HB_MODE_CMP:   hb_pulse = hit_hb;
			vlt_pkg::HB_MODE_EVERY: hb_pulse = 1'b1;
			default:                hb_pulse = 1'b0;
		endcase

		vs  = cur.vsync;
		fld = cur.field;
		if (advance) begin
			if (hit_vss) vs = 1'b1;
			if (hit_vse) vs = 1'b0;   // end wins over start
			if (line == '0) begin
				fld = cfg.interlace ? ~cur.field : 1'b0;
			end
		end

		nxt.scanline = line;
		nxt.vsync    = vs;
		nxt.field    = fld;

		res.line_number    = vlt_pkg::CMP_W'(line);
		res.field_bit      = fld;
		res.vsync_flag     = vs;
		res.blank_flag     = vs || (line_x >= vlt_pkg::EQ_W'(cfg.vs_start));
		res.irq_vblank_in  = advance && hit_vbi;
		res.irq_vblank_out = advance && hit_vbo;
		res.irq_hblank     = advance && hb_pulse;
	end

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the video line timing generator: predictor, driver and monitor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_NS   = 1_000_000;
	localparam int HOLD_LEN   = 300;
	localparam int GAP_PCT    = 24;
	localparam int MAX_REPORT = 50;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [vlt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vlt_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	vlt_cmd_if    cmd_ch ();
	vlt_status_if stat_ch ();

	video_line_timing_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.status    (stat_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the registers and of the line counter state
	vlt_pkg::cfg_t                 shadow_cfg = vlt_pkg::CFG_RESET;
	logic [vlt_pkg::LINE_BITS-1:0] line_q = '0;
	logic                          vsync_q = 1'b0;
	logic                          field_q = 1'b0;

	logic [vlt_pkg::CFG_DAT_W-1:0] reg_words [8];
	bit                            advance_queue [$];
	vlt_pkg::result_t              status_expected [$];

	int          errors = 0;
	int unsigned requests = 0, ticks = 0, settings = 0;
	int unsigned vbi_seen = 0, vbo_seen = 0, hb_seen = 0;
	bit          no_gaps = 1'b0;
	bit          long_hold = 1'b0;
	int unsigned hold_left = 0;

	always #5 clk = ~clk;

	function automatic vlt_pkg::result_t step_line_counter(logic adv);
		logic [vlt_pkg::NEXT_W-1:0] nxt;
		vlt_pkg::result_t r;
		r = '0;
		if (adv) begin
			nxt = vlt_pkg::NEXT_W'(line_q) + 1'b1;
			if (nxt >= vlt_pkg::NEXT_W'(shadow_cfg.line_count))
				nxt = '0;
			line_q = nxt[vlt_pkg::LINE_BITS-1:0];
			r.irq_vblank_in  = (line_q == shadow_cfg.vbi_line);
			r.irq_vblank_out = (line_q == shadow_cfg.vbo_line);
			if (line_q == shadow_cfg.vs_start)
				vsync_q = 1'b1;
			// clear wins when start and end lines coincide
			if (line_q == shadow_cfg.vs_end)
				vsync_q = 1'b0;
			case (shadow_cfg.hb_mode)
				vlt_pkg::HB_MODE_CMP:   r.irq_hblank = (line_q == shadow_cfg.hb_line);
				vlt_pkg::HB_MODE_EVERY: r.irq_hblank = 1'b1;
				default:                r.irq_hblank = 1'b0;
			endcase
			if (line_q == '0)
				field_q = shadow_cfg.interlace ? ~field_q : 1'b0;
		end
		r.line_number = vlt_pkg::CMP_W'(line_q);
		r.field_bit   = field_q;
		r.vsync_flag  = vsync_q;
		r.blank_flag  = vsync_q || (line_q >= shadow_cfg.vs_start);
		return r;
	endfunction

	function automatic logic [vlt_pkg::CFG_DAT_W-1:0] pick_line(int unsigned lc);
		int unsigned top;
		logic [vlt_pkg::CMP_W-1:0] ln;
		top = (lc > 1022) ? 1023 : lc + 1;
		case ($urandom_range(3))
			0:       ln = '0;
			1:       ln = '1;
			default: ln = vlt_pkg::CMP_W'($urandom_range(top));
		endcase
		return vlt_pkg::CFG_DAT_W'({1'($urandom_range(1)), ln});
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORT)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// all eight registers, one per cycle, while nothing is in flight
	task automatic program_regs();
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= vlt_pkg::CFG_IDX_W'(i);
			cfg_data  <= reg_words[i];
			case (vlt_pkg::cfg_reg_t'(i))
				vlt_pkg::REG_LINE_COUNT:
					shadow_cfg.line_count = reg_words[i][vlt_pkg::LCNT_W-1:0];
				vlt_pkg::REG_VBI_LINE:
					shadow_cfg.vbi_line   = reg_words[i][vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_VBO_LINE:
					shadow_cfg.vbo_line   = reg_words[i][vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_VS_START:
					shadow_cfg.vs_start   = reg_words[i][vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_VS_END:
					shadow_cfg.vs_end     = reg_words[i][vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_HB_LINE:
					shadow_cfg.hb_line    = reg_words[i][vlt_pkg::CMP_W-1:0];
				vlt_pkg::REG_HB_MODE:
					shadow_cfg.hb_mode    = reg_words[i][vlt_pkg::MODE_W-1:0];
				vlt_pkg::REG_INTERLACE:
					shadow_cfg.interlace  = reg_words[i][0];
				default: ;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		while (advance_queue.size() != 0 || cmd_ch.valid || status_expected.size() != 0)
			@(posedge clk);
		// margin after the last result
		repeat (3) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				status_expected.push_back(step_line_counter(cmd_ch.advance));
				requests++;
				if (cmd_ch.advance)
					ticks++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (advance_queue.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
					cmd_ch.valid   <= 1'b1;
					cmd_ch.advance <= advance_queue.pop_front();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold, counted in cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold)
				hold_left <= HOLD_LEN;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
		end
	end

	// status monitor
	always @(posedge clk) begin : monitor
		vlt_pkg::result_t want;
		if (arst_n) begin
			if (stat_ch.valid && stat_ch.ready) begin
				if (status_expected.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORT)
						$display("%0t ns: status with no request pending, expected none, actual line %0d",
							$time, stat_ch.line_number);
				end else begin
					want = status_expected.pop_front();
					check_field("line_number", want.line_number, stat_ch.line_number);
					check_field("field_bit", want.field_bit, stat_ch.field_bit);
					check_field("blank_flag", want.blank_flag, stat_ch.blank_flag);
					check_field("vsync_flag", want.vsync_flag, stat_ch.vsync_flag);
					check_field("irq_vblank_in", want.irq_vblank_in, stat_ch.irq_vblank_in);
					check_field("irq_vblank_out", want.irq_vblank_out, stat_ch.irq_vblank_out);
					check_field("irq_hblank", want.irq_hblank, stat_ch.irq_hblank);
				end
				vbi_seen += stat_ch.irq_vblank_in;
				vbo_seen += stat_ch.irq_vblank_out;
				hb_seen  += stat_ch.irq_hblank;
			end
			stat_ch.ready <= (hold_left == 0) && !long_hold &&
				(no_gaps || $urandom_range(99) >= GAP_PCT);
		end
	end

	initial begin
		int unsigned lc;
		int unsigned n;
		cmd_ch.valid   = 1'b0;
		cmd_ch.advance = 1'b0;
		stat_ch.ready  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// short frame, interlace on, masked upper bit on a compare line
		reg_words = '{11'd4, 11'd2, 11'h400, 11'd1, 11'd3, 11'd2, 11'd0, 11'd1};
		program_regs();
		advance_queue.push_back(1'b0);
		for (int i = 0; i < 9; i++)
			advance_queue.push_back(1'b1);
		advance_queue.push_back(1'b0);
		drain();

		// zero line count acts as one; vsync start equals end; hblank every line
		reg_words = '{11'd0, 11'd0, 11'd1023, 11'd0, 11'd0, 11'd0, 11'd2, 11'd0};
		program_regs();
		advance_queue.push_back(1'b1);
		advance_queue.push_back(1'b1);
		advance_queue.push_back(1'b0);
		advance_queue.push_back(1'b1);
		drain();

		// climb a longer frame, then lower the line count under the current line
		reg_words = '{11'd40, 11'd5, 11'd3, 11'd4, 11'd6, 11'd1, 11'd1, 11'd1};
		program_regs();
		for (int i = 0; i < 6; i++)
			advance_queue.push_back(1'b1);
		drain();
		reg_words = '{11'd3, 11'd0, 11'd1, 11'd1, 11'd2, 11'd0, 11'd3, 11'd0};
		program_regs();
		advance_queue.push_back(1'b1);
		advance_queue.push_back(1'b1);
		drain();

		for (int p = 0; p < 14; p++) begin
			if (p == 6) begin
				// counter wraps on its own past line 1023
				reg_words = '{11'd2047, 11'd1023, 11'd0, pick_line(1023), pick_line(1023),
					11'd1023, 11'h004, 11'd1};
				n = 1100;
			end else begin
				case ($urandom_range(9))
					0:       lc = 0;
					1:       lc = 1;
					2:       lc = 1024;
					3:       lc = 2047;
					default: lc = $urandom_range(40, 2);
				endcase
				reg_words[0] = vlt_pkg::CFG_DAT_W'(lc);
				for (int r = 1; r < 6; r++)
					reg_words[r] = pick_line(lc);
				reg_words[6] = vlt_pkg::CFG_DAT_W'($urandom_range(2047));
				reg_words[7] = vlt_pkg::CFG_DAT_W'($urandom_range(2047));
				n = (p == 9) ? 150 : 60;
			end
			program_regs();
			no_gaps = (p == 9);
			for (int i = 0; i < n; i++)
				advance_queue.push_back($urandom_range(99) < 85);
			if (p == 3) begin
				// receiver stalls long enough for the block to back up
				@(posedge clk);
				long_hold <= 1'b1;
				@(posedge clk);
				long_hold <= 1'b0;
			end
			drain();
			no_gaps = 1'b0;
		end

		$display("covered %0d requests, %0d line ticks, over %0d register settings",
			requests, ticks, settings);
		$display("saw %0d vblank-in, %0d vblank-out and %0d hblank pulses",
			vbi_seen, vbo_seen, hb_seen);
		if (status_expected.size() != 0) begin
			errors++;
			$display("%0t ns: %0d expected results never arrived", $time, status_expected.size());
		end
		if (errors == 0) begin
			$display("video_line_timing_generator regression: pass");
		end else begin
			$display("video_line_timing_generator regression: fail");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS * 1ns);
		$display("timeout after %0d ns", LIMIT_NS);
		$display("video_line_timing_generator regression: fail");
		$finish;
	end

endmodule
